// ----- sv/xeu_pkg.sv -----
`timescale 1ns / 1ps
// shared types, character codes and entity tables of the xml entity unescaper
package xeu_pkg;

   // queue between front and back
   localparam int QueueDepth = 4;

   // entity name handling
   localparam int NumNames  = 5;
   localparam int NameDepth = 4;
   localparam int NameLen   = 5;

   // largest code point, values saturate here
   localparam logic [20:0] CodeMax = 21'h10FFFF;

   // character codes
   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharSemi  = 8'h3B;
   localparam logic [7:0] CharQmark = 8'h3F;
   localparam logic [7:0] CharLowX  = 8'h78;
   localparam logic [7:0] CharUpX   = 8'h58;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowF  = 8'h66;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;

   // entity names without the leading ampersand, padded with zero
   localparam logic [7:0] EntText [NumNames][NameLen] = '{
      '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // amp;
      '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
      '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
      '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
      '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}    // apos;
   };
   localparam logic [2:0] EntLen [NumNames] = '{3'd4, 3'd5, 3'd3, 3'd3, 3'd5};
   localparam logic [7:0] EntChar [NumNames] = '{8'h26, 8'h22, 8'h3C, 8'h3E, 8'h27};

   // decoder modes
   typedef enum logic [3:0] {
      ModePlain = 4'b0001,
      ModeName  = 4'b0010,
      ModeHash  = 4'b0100,
      ModeNum   = 4'b1000
   } mode_type;

   // error marker that opens or closes an item's output
   typedef enum logic [1:0] {
      MarkNone  = 2'd0,
      MarkAmp   = 2'd1,
      MarkQmark = 2'd2
   } mark_type;

   // one classified item: leading marker plus name bytes, decoded bytes,
   // trailing marker plus name bytes
   typedef struct packed {
      mark_type        pre_mark;
      mark_type        post_mark;
      logic [2:0]      pre_end;
      logic [2:0]      main_end;
      logic [2:0]      total;
      logic [3:0][7:0] main_bytes;
      logic [3:0][7:0] name_bytes;
      logic            last;
   } cmd_type;

endpackage

// ----- sv/xeu_front.sv -----
`timescale 1ns / 1ps
// front end: accepts raw bytes, tracks entity state and classifies each item
module xeu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_in_last,
   input  logic             q_full,
   output logic             q_push,
   output xeu_pkg::cmd_type q_cmd
);

   xeu_pkg::mode_type mode_ff, mode_in;
   logic [xeu_pkg::NumNames-1:0] cand_ff, cand_in;
   logic [2:0]  count_ff, count_in;
   logic [3:0][7:0] buf_ff, buf_in;
   logic [20:0] code_ff, code_in;
   logic        hex_ff, hex_in;

   logic        accept;
   logic [7:0]  c;

   // name matching
   logic [xeu_pkg::NumNames-1:0] hit, done;
   logic [7:0]  done_char;

   // digit decode and value update
   logic        is_digit;
   logic [3:0]  digit;
   logic [24:0] code_wide, code_times, code_sum;
   logic [20:0] code_sat;

   // utf-8 encoding of the held value
   logic [2:0]      utf_len;
   logic [3:0][7:0] utf_bytes;

   // item classification
   xeu_pkg::mark_type pre_mark, post_mark;
   logic [2:0]      pre_len, post_len, main_len;
   logic [3:0][7:0] main_bytes;
   logic            plain_tail, num_tail;
   logic [2:0]      pre_end, main_end, total;

   assign c         = req_in_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   // which names still match with this byte, and which complete
   always_comb begin
      hit       = '0;
      done      = '0;
      done_char = 8'h00;
      for (int k = xeu_pkg::NumNames - 1; k >= 0; k--) begin
         hit[k] = cand_ff[k] && (xeu_pkg::EntLen[k] > count_ff)
                  && (xeu_pkg::EntText[k][count_ff] == c);
         done[k] = hit[k] && (xeu_pkg::EntLen[k] == count_ff + 3'd1);
         if (done[k]) begin
            done_char = xeu_pkg::EntChar[k];
         end
      end
   end

   // digit of the current base
   always_comb begin
      is_digit = 1'b0;
      digit    = 4'd0;
      if (c >= xeu_pkg::CharZero && c <= xeu_pkg::CharNine) begin
         is_digit = 1'b1;
         digit    = 4'(c - xeu_pkg::CharZero);
      end else if (hex_ff && c >= xeu_pkg::CharLowA && c <= xeu_pkg::CharLowF) begin
         is_digit = 1'b1;
         digit    = 4'(c - xeu_pkg::CharLowA + 8'd10);
      end else if (hex_ff && c >= xeu_pkg::CharUpA && c <= xeu_pkg::CharUpF) begin
         is_digit = 1'b1;
         digit    = 4'(c - xeu_pkg::CharUpA + 8'd10);
      end
   end

   // value times base plus digit, saturated
   always_comb begin
      code_wide  = {4'd0, code_ff};
      code_times = hex_ff ? (code_wide << 4) : ((code_wide << 3) + (code_wide << 1));
      code_sum   = code_times + {21'd0, digit};
      code_sat   = (code_sum > {4'd0, xeu_pkg::CodeMax}) ? xeu_pkg::CodeMax : code_sum[20:0];
   end

   // utf-8 bytes of the held value
   always_comb begin
      utf_bytes = '0;
      if (code_ff < 21'h80) begin
         utf_len      = 3'd1;
         utf_bytes[0] = code_ff[7:0];
      end else if (code_ff < 21'h800) begin
         utf_len      = 3'd2;
         utf_bytes[0] = {3'b110, code_ff[10:6]};
         utf_bytes[1] = {2'b10, code_ff[5:0]};
      end else if (code_ff < 21'h10000) begin
         utf_len      = 3'd3;
         utf_bytes[0] = {4'b1110, code_ff[15:12]};
         utf_bytes[1] = {2'b10, code_ff[11:6]};
         utf_bytes[2] = {2'b10, code_ff[5:0]};
      end else begin
         utf_len      = 3'd4;
         utf_bytes[0] = {5'b11110, code_ff[20:18]};
         utf_bytes[1] = {2'b10, code_ff[17:12]};
         utf_bytes[2] = {2'b10, code_ff[11:6]};
         utf_bytes[3] = {2'b10, code_ff[5:0]};
      end
   end

   // next state and item classification
   always_comb begin
      mode_in    = mode_ff;
      cand_in    = cand_ff;
      count_in   = count_ff;
      buf_in     = buf_ff;
      code_in    = code_ff;
      hex_in     = hex_ff;
      pre_mark   = xeu_pkg::MarkNone;
      post_mark  = xeu_pkg::MarkNone;
      pre_len    = 3'd0;
      post_len   = 3'd0;
      main_len   = 3'd0;
      main_bytes = '0;
      plain_tail = 1'b0;
      num_tail   = 1'b0;

      unique case (mode_ff)
         xeu_pkg::ModeName: begin
            if (count_ff == 3'd0 && c == xeu_pkg::CharHash) begin
               mode_in = xeu_pkg::ModeHash;
               code_in = '0;
               hex_in  = 1'b0;
            end else if (|done) begin
               main_len      = 3'd1;
               main_bytes[0] = done_char;
               mode_in       = xeu_pkg::ModePlain;
               count_in      = 3'd0;
            end else if (|hit) begin
               buf_in[count_ff[1:0]] = c;
               count_in = count_ff + 3'd1;
               cand_in  = hit;
            end else begin
               // unknown name: ampersand, buffered bytes, then the byte as text
               pre_mark   = xeu_pkg::MarkAmp;
               pre_len    = count_ff;
               count_in   = 3'd0;
               plain_tail = 1'b1;
            end
         end
         xeu_pkg::ModeHash: begin
            mode_in = xeu_pkg::ModeNum;
            if (c == xeu_pkg::CharLowX || c == xeu_pkg::CharUpX) begin
               hex_in = 1'b1;
            end else begin
               num_tail = 1'b1;
            end
         end
         xeu_pkg::ModeNum: begin
            num_tail = 1'b1;
         end
         default: begin
            plain_tail = 1'b1;
         end
      endcase

      // numeric reference byte
      if (num_tail) begin
         if (is_digit) begin
            code_in = code_sat;
         end else if (c == xeu_pkg::CharSemi) begin
            main_len   = utf_len;
            main_bytes = utf_bytes;
            mode_in    = xeu_pkg::ModePlain;
         end else begin
            pre_mark   = xeu_pkg::MarkQmark;
            plain_tail = 1'b1;
         end
      end

      // byte handled as text
      if (plain_tail) begin
         if (c == xeu_pkg::CharAmp) begin
            mode_in  = xeu_pkg::ModeName;
            count_in = 3'd0;
            cand_in  = '1;
         end else begin
            mode_in       = xeu_pkg::ModePlain;
            main_len      = 3'd1;
            main_bytes[0] = c;
         end
      end

      // end of string flushes an open entity
      if (req_in_last) begin
         if (mode_in == xeu_pkg::ModeName) begin
            post_mark = xeu_pkg::MarkAmp;
            post_len  = count_in;
         end else if (mode_in == xeu_pkg::ModeHash || mode_in == xeu_pkg::ModeNum) begin
            post_mark = xeu_pkg::MarkQmark;
         end
         mode_in  = xeu_pkg::ModePlain;
         count_in = 3'd0;
      end

      pre_end  = 3'((pre_mark != xeu_pkg::MarkNone) ? 1 : 0) + pre_len;
      main_end = pre_end + main_len;
      total    = main_end + 3'((post_mark != xeu_pkg::MarkNone) ? 1 : 0) + post_len;
   end

   // item toward the back end
   assign q_push = accept && (total != 3'd0);
   always_comb begin
      q_cmd            = '0;
      q_cmd.pre_mark   = pre_mark;
      q_cmd.post_mark  = post_mark;
      q_cmd.pre_end    = pre_end;
      q_cmd.main_end   = main_end;
      q_cmd.total      = total;
      q_cmd.main_bytes = main_bytes;
      q_cmd.name_bytes = buf_in;
      q_cmd.last       = req_in_last;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= xeu_pkg::ModePlain;
         cand_ff  <= '1;
         count_ff <= 3'd0;
         code_ff  <= '0;
         hex_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         cand_ff  <= cand_in;
         count_ff <= count_in;
         code_ff  <= code_in;
         hex_ff   <= hex_in;
      end
   end

   // name bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
   end

endmodule

// ----- sv/xeu_queue.sv -----
`timescale 1ns / 1ps
// small first-in first-out queue of classified items between front and back
module xeu_queue #(
   parameter int Depth = xeu_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xeu_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output xeu_pkg::cmd_type head_cmd
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   xeu_pkg::cmd_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full      = (cnt_ff == CntW'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- sv/xeu_back.sv -----
`timescale 1ns / 1ps
// back end: expands each classified item into output bytes, one per cycle while rsp_ready is high
module xeu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  xeu_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_error,
   output logic             rsp_out_last
);

   xeu_pkg::cmd_type cmd_ff;
   logic       busy_ff;
   logic [2:0] idx_ff;
   logic       at_end, load;
   logic [2:0] main_off, post_off, name_off;

   assign at_end    = (idx_ff == cmd_ff.total - 3'd1);
   assign load      = q_valid && (!busy_ff || (rsp_ready && at_end));
   assign q_pop     = load;
   assign rsp_valid = busy_ff;

   // pick the byte at the current position of the item
   always_comb begin
      main_off      = idx_ff - cmd_ff.pre_end;
      post_off      = idx_ff - cmd_ff.main_end;
      name_off      = 3'd0;
      rsp_out_byte  = 8'h00;
      rsp_out_error = 1'b0;
      rsp_out_last  = cmd_ff.last && at_end;
      if (idx_ff < cmd_ff.pre_end) begin
         // leading marker and the flushed name bytes
         if (idx_ff == 3'd0) begin
            rsp_out_error = 1'b1;
            rsp_out_byte  = (cmd_ff.pre_mark == xeu_pkg::MarkAmp) ? xeu_pkg::CharAmp
                                                                 : xeu_pkg::CharQmark;
         end else begin
            name_off     = idx_ff - 3'd1;
            rsp_out_byte = cmd_ff.name_bytes[name_off[1:0]];
         end
      end else if (idx_ff < cmd_ff.main_end) begin
         rsp_out_byte = cmd_ff.main_bytes[main_off[1:0]];
      end else begin
         // trailing marker at end of string and the flushed name bytes
         if (post_off == 3'd0) begin
            rsp_out_error = 1'b1;
            rsp_out_byte  = (cmd_ff.post_mark == xeu_pkg::MarkAmp) ? xeu_pkg::CharAmp
                                                                  : xeu_pkg::CharQmark;
         end else begin
            name_off     = post_off - 3'd1;
            rsp_out_byte = cmd_ff.name_bytes[name_off[1:0]];
         end
      end
   end

   // position within the current item
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= 3'd0;
      end else if (busy_ff && rsp_ready) begin
         if (at_end) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end

   // current item
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= q_cmd;
      end
   end

endmodule

// ----- sv/xml_entity_unescaper.sv -----
`timescale 1ns / 1ps
// xml entity unescaper: one raw byte in, zero to six unescaped bytes out
// an item reaches the output through a queue slot and then the back end's item register
// throughput: one input byte per cycle while the queue is not full; the back end sends
//   an item's bytes one by one and, while busy, loads the next item only as the last byte is taken
// the queue of QueueDepth items lets the input run on while an expansion drains
// reset (synchronous, active high) returns to plain text and empties the queue
module xml_entity_unescaper #(
   parameter int QueueDepth = xeu_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_error,
   output logic       rsp_out_last
);

   xeu_pkg::cmd_type push_cmd, head_cmd;
   logic push, full, pop, not_empty;

   // classify incoming bytes
   xeu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   // decouple front and back
   xeu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   // expand items into output bytes
   xeu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (not_empty),
      .q_cmd         (head_cmd),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_error (rsp_out_error),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the xml entity unescaper with its own decoder predictor
module testbench;

   localparam int IdleLimit   = 2000;
   localparam int HoldCycles  = 300;
   localparam int DrainCycles = 20;
   localparam int MaxReports  = 10;

   // one unescaped output byte as the block should deliver it
   typedef struct packed {
      logic [7:0] data;
      logic       err;
      logic       last;
   } decoded_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_error;
   logic       rsp_out_last;

   // entity names after the ampersand and the characters they stand for
   string entity_names [5] = '{"amp;", "quot;", "lt;", "gt;", "apos;"};
   string entity_chars = "&\"<>'";

   // decoder state of the predictor
   xeu_pkg::mode_type dec_mode;
   logic [7:0]       name_bytes [4];
   int               name_len;
   logic [20:0]      code_point;
   logic             hex_digits;
   decoded_byte_type step_bytes [$];
   decoded_byte_type decoded_q [$];
   decoded_byte_type head_byte;

   // traffic shaping and bookkeeping
   int burst_left;
   int gap_pct;
   int stall_pct;
   int items_sent;
   int failure_count;
   int result_count;
   int quiet_cycles;
   int hold_left;
   int run_left;
   bit run_ready;
   bit hold_start;

   xml_entity_unescaper u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_error (rsp_out_error),
      .rsp_out_last  (rsp_out_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void put_byte(logic [7:0] b, logic e);
      step_bytes.push_back({b, e, 1'b0});
   endfunction

   // plain text: pass through, or open an entity on an ampersand
   function automatic void plain_char(logic [7:0] c);
      dec_mode = xeu_pkg::ModePlain;
      if (c == xeu_pkg::CharAmp) begin
         dec_mode = xeu_pkg::ModeName;
         name_len = 0;
      end else begin
         put_byte(c, 1'b0);
      end
   endfunction

   // give up on a name: flagged ampersand, then the buffered name text
   function automatic void flush_name();
      put_byte(xeu_pkg::CharAmp, 1'b1);
      for (int i = 0; i < name_len; i++)
         put_byte(name_bytes[i], 1'b0);
      name_len = 0;
      dec_mode = xeu_pkg::ModePlain;
   endfunction

   function automatic int digit_value(logic [7:0] c);
      if (c >= xeu_pkg::CharZero && c <= xeu_pkg::CharNine)
         return c - xeu_pkg::CharZero;
      if (hex_digits && c >= xeu_pkg::CharLowA && c <= xeu_pkg::CharLowF)
         return c - xeu_pkg::CharLowA + 10;
      if (hex_digits && c >= xeu_pkg::CharUpA && c <= xeu_pkg::CharUpF)
         return c - xeu_pkg::CharUpA + 10;
      return -1;
   endfunction

   // digits accumulate with saturation, semicolon emits utf-8, anything else aborts
   function automatic void number_char(logic [7:0] c);
      int          d;
      logic [31:0] v;
      d = digit_value(c);
      if (d >= 0) begin
         v = {11'd0, code_point} * (hex_digits ? 32'd16 : 32'd10) + 32'(d);
         code_point = (v > {11'd0, xeu_pkg::CodeMax}) ? xeu_pkg::CodeMax : v[20:0];
      end else if (c == xeu_pkg::CharSemi) begin
         if (code_point < 21'h80) begin
            put_byte(code_point[7:0], 1'b0);
         end else if (code_point < 21'h800) begin
            put_byte({3'b110, code_point[10:6]}, 1'b0);
            put_byte({2'b10, code_point[5:0]}, 1'b0);
         end else if (code_point < 21'h10000) begin
            put_byte({4'b1110, code_point[15:12]}, 1'b0);
            put_byte({2'b10, code_point[11:6]}, 1'b0);
            put_byte({2'b10, code_point[5:0]}, 1'b0);
         end else begin
            put_byte({5'b11110, code_point[20:18]}, 1'b0);
            put_byte({2'b10, code_point[17:12]}, 1'b0);
            put_byte({2'b10, code_point[11:6]}, 1'b0);
            put_byte({2'b10, code_point[5:0]}, 1'b0);
         end
         dec_mode = xeu_pkg::ModePlain;
      end else begin
         put_byte(xeu_pkg::CharQmark, 1'b1);
         plain_char(c);
      end
   endfunction

   // name collection: stays while the text is a prefix of some entity name
   function automatic void name_char(logic [7:0] c);
      bit    is_prefix;
      bit    ok;
      string nm;
      is_prefix = 1'b0;
      if (name_len == 0 && c == xeu_pkg::CharHash) begin
         dec_mode = xeu_pkg::ModeHash;
         code_point = '0;
         hex_digits = 1'b0;
         return;
      end
      for (int k = 0; k < 5; k++) begin
         nm = entity_names[k];
         ok = nm.len() > name_len;
         for (int i = 0; i < name_len; i++)
            if (ok && nm[i] != name_bytes[i])
               ok = 1'b0;
         if (ok && nm[name_len] == c) begin
            if (nm.len() == name_len + 1) begin
               put_byte(entity_chars[k], 1'b0);
               name_len = 0;
               dec_mode = xeu_pkg::ModePlain;
               return;
            end
            is_prefix = 1'b1;
         end
      end
      if (is_prefix && name_len < 4) begin
         name_bytes[name_len] = c;
         name_len++;
         return;
      end
      flush_name();
      plain_char(c);
   endfunction

   // expected output bytes of one accepted item
   function automatic void predict_item(logic [7:0] c, logic l);
      decoded_byte_type r;
      step_bytes.delete();
      case (dec_mode)
         xeu_pkg::ModeName: name_char(c);
         xeu_pkg::ModeHash: begin
            dec_mode = xeu_pkg::ModeNum;
            if (c == xeu_pkg::CharLowX || c == xeu_pkg::CharUpX)
               hex_digits = 1'b1;
            else
               number_char(c);
         end
         xeu_pkg::ModeNum: number_char(c);
         default: plain_char(c);
      endcase
      // end of string closes whatever entity is open
      if (l) begin
         if (dec_mode == xeu_pkg::ModeName)
            flush_name();
         else if (dec_mode == xeu_pkg::ModeHash || dec_mode == xeu_pkg::ModeNum)
            put_byte(xeu_pkg::CharQmark, 1'b1);
         dec_mode = xeu_pkg::ModePlain;
         name_len = 0;
      end
      foreach (step_bytes[i]) begin
         r = step_bytes[i];
         if (l && i == step_bytes.size() - 1)
            r.last = 1'b1;
         decoded_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- driving

   // offer one item, with random gaps between bursts
   task automatic send_byte(logic [7:0] b, logic l);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(99) < gap_pct) ? $urandom_range(6, 1) : 0;
         burst_left = $urandom_range(12, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(b, l);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_text(string s, bit end_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_last && i == s.len() - 1);
   endtask

   // one random fragment: plain bytes, a named entity, or a numeric reference
   task automatic send_random_piece();
      logic [7:0] piece [$];
      logic [7:0] ch;
      int         kind;
      int         n;
      int         d;
      bit         hex;
      string      nm;
      kind = $urandom_range(99);
      if (kind < 30) begin
         n = $urandom_range(4, 1);
         repeat (n) piece.push_back(8'($urandom_range(255)));
      end else if (kind < 60) begin
         // whole names mostly, some cut short and followed by a random byte
         nm = entity_names[$urandom_range(4)];
         piece.push_back(xeu_pkg::CharAmp);
         n = (kind < 48) ? nm.len() : $urandom_range(nm.len() - 1);
         for (int i = 0; i < n; i++)
            piece.push_back(nm[i]);
         if (kind >= 48)
            piece.push_back(8'($urandom_range(255)));
      end else begin
         piece.push_back(xeu_pkg::CharAmp);
         piece.push_back(xeu_pkg::CharHash);
         hex = ($urandom_range(1) == 1);
         if (hex)
            piece.push_back($urandom_range(1) ? xeu_pkg::CharLowX : xeu_pkg::CharUpX);
         // empty, short, or long enough to saturate
         if (kind >= 94)
            n = 0;
         else if ($urandom_range(9) == 0)
            n = $urandom_range(9, 6);
         else
            n = $urandom_range(hex ? 6 : 4, 1);
         for (int i = 0; i < n; i++) begin
            d = hex ? $urandom_range(15) : $urandom_range(9);
            if (d < 10)
               ch = 8'(xeu_pkg::CharZero + d);
            else
               ch = 8'(($urandom_range(1) ? xeu_pkg::CharLowA : xeu_pkg::CharUpA) + d - 10);
            piece.push_back(ch);
         end
         // broken references end on a random byte instead of the semicolon
         if (kind >= 86 && kind < 94)
            piece.push_back(8'($urandom_range(255)));
         else
            piece.push_back(xeu_pkg::CharSemi);
      end
      foreach (piece[i])
         send_byte(piece[i], $urandom_range(15) == 0);
   endtask

   // ---------------------------------------------------------------- receiver

   // stall pattern of its own, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_ready = ($urandom_range(99) >= stall_pct);
            run_left = $urandom_range(8, 1);
         end
         run_left--;
         rsp_ready <= run_ready;
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic note_failure(string msg);
      failure_count++;
      if (failure_count <= MaxReports)
         $display("error at %0t: %s", $realtime, msg);
   endtask

   // compare every accepted output byte with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (decoded_q.size() == 0) begin
            note_failure($sformatf("unexpected byte %h error %b last %b",
               rsp_out_byte, rsp_out_error, rsp_out_last));
         end else begin
            head_byte = decoded_q.pop_front();
            if (rsp_out_byte !== head_byte.data || rsp_out_error !== head_byte.err ||
                rsp_out_last !== head_byte.last)
               note_failure($sformatf(
                  "byte %0d: data exp %h got %h, error exp %b got %b, last exp %b got %b",
                  result_count, head_byte.data, rsp_out_byte, head_byte.err,
                  rsp_out_error, head_byte.last, rsp_out_last));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IdleLimit) begin
            $display("timeout: no item moved for %0d cycles", IdleLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic reset_block();
      dec_mode = xeu_pkg::ModePlain;
      name_len = 0;
      code_point = '0;
      hex_digits = 1'b0;
      burst_left = 0;
      gap_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      failure_count = 0;
      result_count = 0;
      quiet_cycles = 0;
      hold_left = 0;
      run_left = 0;
      hold_start = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   endtask

   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_named_entities();
      send_text("&lt;&apos;", 1'b0);
   endtask

   // empty reference, surrogate code point, saturation
   task automatic test_numeric_refs();
      send_text("&#;", 1'b0);
      send_text("&#xDFFF;", 1'b0);
      send_text("&#9999999;", 1'b0);
   endtask

   // unknown name and numeric reference cut off by a letter
   task automatic test_malformed_entities();
      send_text("&qx", 1'b0);
      send_text("&#1a", 1'b0);
   endtask

   // string ends inside a name and inside a number
   task automatic test_end_of_string();
      send_text("&am", 1'b1);
      send_text("&#4", 1'b1);
   endtask

   task automatic test_random_text(int count, int gaps, int stalls);
      int target;
      gap_pct = gaps;
      stall_pct = stalls;
      target = items_sent + count;
      while (items_sent < target)
         send_random_piece();
   endtask

   // receiver holds off while the sender keeps offering wide expansions
   task automatic test_output_hold_off();
      gap_pct = 0;
      stall_pct = 0;
      hold_start = 1'b1;
      repeat (5) send_text("&#x10FFFF;", 1'b0);
      send_text("&quot;", 1'b1);
   endtask

   initial begin
      reset_block();
      test_plain_bytes();
      test_named_entities();
      test_numeric_refs();
      test_malformed_entities();
      test_end_of_string();
      test_random_text(110, 0, 0);
      test_random_text(130, 30, 30);
      test_random_text(130, 70, 60);
      test_output_hold_off();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failure_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- xml_entity_unescaper.f -----
sv/xeu_pkg.sv
sv/xeu_front.sv
sv/xeu_queue.sv
sv/xeu_back.sv
sv/xml_entity_unescaper.sv
bench/testbench.sv
